// File: rtl/sbrc_pkg.sv
// Shared constants, types and helper functions for the substitution/rotate block cipher.
package sbrc_pkg;

   localparam int ROUNDS      = 16;
   localparam int RND_W       = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam int NUM_TABLES  = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_ENCRYPT = 2'd1;
   localparam logic [1:0] ACT_DECRYPT = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ENCRYPT,
      OP_DECRYPT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [2:0]  table_number;
      logic [7:0]  table_entry;
      logic [7:0]  entry_value;
      logic [63:0] data_block;
   } item_type;

   typedef enum logic {
      BK_IDLE,
      BK_ROUND
   } back_state_type;

   function automatic logic [63:0] rotl1(input logic [63:0] x);
      return {x[62:0], x[63]};
   endfunction

   function automatic logic [63:0] rotr1(input logic [63:0] x);
      return {x[0], x[63:1]};
   endfunction

endpackage

// File: rtl/sbrc_front.sv
// Front end: accept requests, classify the action and hand items to the queue.
module sbrc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [2:0]        req_table_number,
   input  logic [7:0]        req_table_entry,
   input  logic [7:0]        req_entry_value,
   input  logic [63:0]       req_data_block,
   output logic              push_valid,
   output sbrc_pkg::item_type push_item,
   input  logic              push_full
);

   logic               front_valid_ff;
   logic               front_valid_in;
   sbrc_pkg::item_type item_ff;
   sbrc_pkg::item_type item_in;
   sbrc_pkg::item_type new_item;
   logic               keep;
   logic               accept;
   logic               push;

   assign push      = front_valid_ff && !push_full;
   assign req_stall = front_valid_ff && push_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      new_item.table_number = req_table_number;
      new_item.table_entry  = req_table_entry;
      new_item.entry_value  = req_entry_value;
      new_item.data_block   = req_data_block;
      new_item.op           = sbrc_pkg::OP_LOAD;
      keep                  = 1'b1;
      unique case (req_action)
         sbrc_pkg::ACT_LOAD:    new_item.op = sbrc_pkg::OP_LOAD;
         sbrc_pkg::ACT_ENCRYPT: new_item.op = sbrc_pkg::OP_ENCRYPT;
         sbrc_pkg::ACT_DECRYPT: new_item.op = sbrc_pkg::OP_DECRYPT;
         default:               keep        = 1'b0;
      endcase
   end

   always_comb begin
      if (accept) begin
         front_valid_in = keep;
         item_in        = new_item;
      end else begin
         front_valid_in = front_valid_ff && !push;
         item_in        = item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      item_ff <= item_in;
   end

   assign push_valid = push;
   assign push_item  = item_ff;

endmodule

// File: rtl/sbrc_queue.sv
// Short queue between the front end and the round engine.
module sbrc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  sbrc_pkg::item_type push_item,
   output logic               push_full,
   output logic               pop_valid,
   output sbrc_pkg::item_type pop_item,
   input  logic               pop
);

   sbrc_pkg::item_type                 entry_ff [sbrc_pkg::QUEUE_DEPTH];
   logic [sbrc_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [sbrc_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [sbrc_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [sbrc_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [sbrc_pkg::QCNT_W-1:0]        count_ff;
   logic [sbrc_pkg::QCNT_W-1:0]        count_in;
   logic                               do_push;
   logic                               do_pop;

   localparam logic [sbrc_pkg::QPTR_W-1:0] LastPtr = sbrc_pkg::QPTR_W'(sbrc_pkg::QUEUE_DEPTH - 1);
   localparam logic [sbrc_pkg::QCNT_W-1:0] FullCnt = sbrc_pkg::QCNT_W'(sbrc_pkg::QUEUE_DEPTH);

   assign push_full = (count_ff == FullCnt);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/sbrc_back.sv
// Round engine: table loads, sixteen rounds per block and the result register.
module sbrc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [63:0]        cipher_key,
   input  logic               pop_valid,
   input  sbrc_pkg::item_type pop_item,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_result_block,
   output logic               rsp_was_decrypt
);

   localparam logic [sbrc_pkg::RND_W-1:0] LastRound = sbrc_pkg::RND_W'(sbrc_pkg::ROUNDS - 1);

   logic [7:0] fwd_mem [sbrc_pkg::NUM_TABLES][sbrc_pkg::TABLE_DEPTH];
   logic [7:0] inv_mem [sbrc_pkg::NUM_TABLES][sbrc_pkg::TABLE_DEPTH];
   logic [7:0] fwd_rd_ff [sbrc_pkg::NUM_TABLES];
   logic [7:0] inv_rd_ff [sbrc_pkg::NUM_TABLES];

   sbrc_pkg::back_state_type state_ff;
   sbrc_pkg::back_state_type state_in;
   logic [sbrc_pkg::RND_W-1:0] cnt_ff;
   logic [sbrc_pkg::RND_W-1:0] cnt_in;
   logic                       decrypt_ff;
   logic                       decrypt_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [63:0]                rsp_block_ff;
   logic [63:0]                rsp_block_in;
   logic                       rsp_decrypt_ff;
   logic                       rsp_decrypt_in;

   logic        start;
   logic        tbl_we;
   logic        rd_en;
   logic        last;
   logic        result_load;
   logic [63:0] cur_block;
   logic [63:0] addr_word;
   logic [63:0] final_block;

   always_comb begin
      for (int b = 0; b < sbrc_pkg::NUM_TABLES; b++) begin
         cur_block[63-8*b -: 8] = decrypt_ff ? inv_rd_ff[b] : fwd_rd_ff[b];
      end
   end

   assign last        = (cnt_ff == LastRound);
   assign final_block = decrypt_ff ? (cur_block ^ cipher_key) : sbrc_pkg::rotl1(cur_block);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbrc_pkg::BK_IDLE: begin
            if (start) begin
               state_in = sbrc_pkg::BK_ROUND;
            end
         end
         sbrc_pkg::BK_ROUND: begin
            if (result_load) begin
               state_in = sbrc_pkg::BK_IDLE;
            end
         end
         default: state_in = sbrc_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop         = 1'b0;
      start       = 1'b0;
      tbl_we      = 1'b0;
      rd_en       = 1'b0;
      result_load = 1'b0;
      addr_word   = decrypt_ff ? sbrc_pkg::rotr1(cur_block ^ cipher_key)
                               : (sbrc_pkg::rotl1(cur_block) ^ cipher_key);
      unique case (state_ff)
         sbrc_pkg::BK_IDLE: begin
            pop       = pop_valid;
            tbl_we    = pop_valid && (pop_item.op == sbrc_pkg::OP_LOAD);
            start     = pop_valid && (pop_item.op != sbrc_pkg::OP_LOAD);
            rd_en     = start;
            addr_word = (pop_item.op == sbrc_pkg::OP_DECRYPT)
                        ? sbrc_pkg::rotr1(pop_item.data_block)
                        : (pop_item.data_block ^ cipher_key);
         end
         sbrc_pkg::BK_ROUND: begin
            rd_en       = !last;
            result_load = last && (!rsp_valid_ff || !rsp_stall);
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      cnt_in     = cnt_ff;
      decrypt_in = decrypt_ff;
      if (start) begin
         cnt_in     = '0;
         decrypt_in = (pop_item.op == sbrc_pkg::OP_DECRYPT);
      end else if (rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_block_in   = rsp_block_ff;
      rsp_decrypt_in = rsp_decrypt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (result_load) begin
         rsp_valid_in   = 1'b1;
         rsp_block_in   = final_block;
         rsp_decrypt_in = decrypt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbrc_pkg::BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      decrypt_ff     <= decrypt_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_decrypt_ff <= rsp_decrypt_in;
   end

   for (genvar g = 0; g < sbrc_pkg::NUM_TABLES; g++) begin : g_table
      always_ff @(posedge clock) begin
         if (tbl_we && (pop_item.table_number == 3'(g))) begin
            fwd_mem[g][pop_item.table_entry] <= pop_item.entry_value;
            inv_mem[g][pop_item.entry_value] <= pop_item.table_entry;
         end
         if (rd_en) begin
            fwd_rd_ff[g] <= fwd_mem[g][addr_word[63-8*g -: 8]];
            inv_rd_ff[g] <= inv_mem[g][addr_word[63-8*g -: 8]];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_block = rsp_block_ff;
   assign rsp_was_decrypt  = rsp_decrypt_ff;

endmodule

// File: rtl/sbox_rotate_block_cipher_top.sv
// Top level of the substitution/rotate block cipher.
//
// Requests arrive on the req_ channel (valid/stall). Action load writes one
// entry of a forward table and the matching inverse entry; encrypt and
// decrypt run sixteen rounds on req_data_block; any other action is dropped.
// Each encrypt or decrypt returns one result on the rsp_ channel; loads return
// nothing. The user must write the round key through csr_write_enable and
// csr_write_data only while the block is idle; the block does not enforce it.
// A front register and a two-entry queue sit ahead of the round engine, so
// requests keep being taken while the engine works. For a block the engine
// first issues a table read and then runs the rounds in turn; each round is
// a single read of the eight tables whose registered data feeds the next
// address.
// Reset clears the key, the queue and the engine; table contents are kept and
// must be loaded before use. While rsp_stall is high a valid result holds
// and the engine waits on its last round; requests back up into the queue and
// then req_stall rises.
module sbox_rotate_block_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_table_number,
   input  logic [7:0]  req_table_entry,
   input  logic [7:0]  req_entry_value,
   input  logic [63:0] req_data_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_block,
   output logic        rsp_was_decrypt,
   input  logic        csr_write_enable,
   input  logic [63:0] csr_write_data
);

   logic [63:0]        csr_key_ff;
   logic [63:0]        csr_key_in;
   logic               push_valid;
   sbrc_pkg::item_type push_item;
   logic               push_full;
   logic               pop_valid;
   sbrc_pkg::item_type pop_item;
   logic               pop;

   assign csr_key_in = csr_write_enable ? csr_write_data : csr_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_key_ff <= '0;
      end else begin
         csr_key_ff <= csr_key_in;
      end
   end

   sbrc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_table_number (req_table_number),
      .req_table_entry  (req_table_entry),
      .req_entry_value  (req_entry_value),
      .req_data_block   (req_data_block),
      .push_valid       (push_valid),
      .push_item        (push_item),
      .push_full        (push_full)
   );

   sbrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_full  (push_full),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   sbrc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cipher_key       (csr_key_ff),
      .pop_valid        (pop_valid),
      .pop_item         (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_block (rsp_result_block),
      .rsp_was_decrypt  (rsp_was_decrypt)
   );

endmodule

// File: rtl/sbrc_checker.sv
// Port-level checks for the block cipher top level, bound to it.
module sbrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_block,
   input logic        rsp_was_decrypt
);

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result_block) && $stable(rsp_was_decrypt))
      else $error("stalled result changed");

   a_stall_after_request : assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && !req_stall))
      else $error("input stalled without a request taken");

endmodule

bind sbox_rotate_block_cipher_top sbrc_checker u_sbrc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_block (rsp_result_block),
   .rsp_was_decrypt  (rsp_was_decrypt)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the substitution/rotate block cipher top level.
module testbench;

   localparam logic [1:0] ACT_IGNORED = 2'd3;
   localparam int         MAX_GAP     = 13;
   localparam int         SETTLE      = 40;
   localparam int         HOLD_OFF    = 300;
   localparam int         PHASES      = 5;
   localparam int         PHASE_ITEMS = 220;

   typedef struct {
      logic [1:0]  action;
      logic [2:0]  table_number;
      logic [7:0]  table_entry;
      logic [7:0]  entry_value;
      logic [63:0] data_block;
   } request_type;

   typedef struct {
      logic [63:0] result_block;
      logic        was_decrypt;
   } block_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [2:0]  req_table_number = '0;
   logic [7:0]  req_table_entry = '0;
   logic [7:0]  req_entry_value = '0;
   logic [63:0] req_data_block = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_block;
   logic        rsp_was_decrypt;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;

   request_type      pending_requests[$];
   block_result_type blocks_due[$];
   logic [7:0]    fwd_sbox  [sbrc_pkg::NUM_TABLES][sbrc_pkg::TABLE_DEPTH];
   logic [7:0]    inv_sbox  [sbrc_pkg::NUM_TABLES][sbrc_pkg::TABLE_DEPTH];
   logic [7:0]    plan_sbox [sbrc_pkg::NUM_TABLES][sbrc_pkg::TABLE_DEPTH];
   logic [63:0]   round_key = '0;
   int            error_count = 0;
   int            requests_queued = 0;
   int            requests_taken = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   int            hold_left = 0;
   bit            send_quiet = 1'b0;
   bit            recv_quiet = 1'b0;
   bit            hold_request = 1'b0;
   bit            req_taken = 1'b0;

   sbox_rotate_block_cipher_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_table_number (req_table_number),
      .req_table_entry  (req_table_entry),
      .req_entry_value  (req_entry_value),
      .req_data_block   (req_data_block),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_block (rsp_result_block),
      .rsp_was_decrypt  (rsp_was_decrypt),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) begin
         $display("ERROR at %0t: %s", $time, what);
      end
   endtask

   function automatic logic [63:0] encipher(input logic [63:0] blk);
      logic [63:0] x;
      logic [63:0] s;
      x = blk;
      for (int r = 0; r < sbrc_pkg::ROUNDS; r++) begin
         x = x ^ round_key;
         for (int b = 0; b < sbrc_pkg::NUM_TABLES; b++) begin
            s[63 - 8 * b -: 8] = fwd_sbox[b][x[63 - 8 * b -: 8]];
         end
         x = {s[62:0], s[63]};
      end
      return x;
   endfunction

   function automatic logic [63:0] decipher(input logic [63:0] blk);
      logic [63:0] x;
      logic [63:0] s;
      x = blk;
      for (int r = 0; r < sbrc_pkg::ROUNDS; r++) begin
         x = {x[0], x[63:1]};
         for (int b = 0; b < sbrc_pkg::NUM_TABLES; b++) begin
            s[63 - 8 * b -: 8] = inv_sbox[b][x[63 - 8 * b -: 8]];
         end
         x = s ^ round_key;
      end
      return x;
   endfunction

   function automatic void absorb_request(input request_type rq);
      block_result_type res;
      case (rq.action)
         sbrc_pkg::ACT_LOAD: begin
            fwd_sbox[rq.table_number][rq.table_entry] = rq.entry_value;
            inv_sbox[rq.table_number][rq.entry_value] = rq.table_entry;
         end
         sbrc_pkg::ACT_ENCRYPT: begin
            res.result_block = encipher(rq.data_block);
            res.was_decrypt  = 1'b0;
            blocks_due.push_back(res);
         end
         sbrc_pkg::ACT_DECRYPT: begin
            res.result_block = decipher(rq.data_block);
            res.was_decrypt  = 1'b1;
            blocks_due.push_back(res);
         end
         default: begin
         end
      endcase
   endfunction

   function automatic request_type random_request(input logic [1:0] action);
      request_type rq;
      rq.action       = action;
      rq.table_number = 3'($urandom_range(0, 7));
      rq.table_entry  = 8'($urandom_range(0, 255));
      rq.entry_value  = 8'($urandom_range(0, 255));
      rq.data_block   = {$urandom, $urandom};
      return rq;
   endfunction

   function automatic void queue_request(input request_type rq);
      pending_requests.push_back(rq);
      requests_queued++;
   endfunction

   function automatic void queue_load(input int t, input int e, input logic [7:0] v);
      request_type rq;
      rq = random_request(sbrc_pkg::ACT_LOAD);
      rq.table_number = 3'(t);
      rq.table_entry  = 8'(e);
      rq.entry_value  = v;
      plan_sbox[t][e] = v;
      queue_request(rq);
   endfunction

   function automatic void queue_block(input logic [1:0] action, input logic [63:0] blk);
      request_type rq;
      rq = random_request(action);
      rq.data_block = blk;
      queue_request(rq);
   endfunction

   function automatic void queue_swap(input int t, input int a, input int b);
      logic [7:0] va;
      logic [7:0] vb;
      va = plan_sbox[t][a];
      vb = plan_sbox[t][b];
      queue_load(t, a, vb);
      queue_load(t, b, va);
   endfunction

   function automatic int find_value(input int t, input logic [7:0] v);
      for (int e = 0; e < sbrc_pkg::TABLE_DEPTH; e++) begin
         if (plan_sbox[t][e] == v) return e;
      end
      return 0;
   endfunction

   task automatic drain();
      while (requests_taken != requests_queued || blocks_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] value);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      round_key = value;
   endtask

   always @(negedge clock) begin : driver
      request_type nxt;
      logic        offer;
      if (reset) begin
      end else if (req_valid && !req_taken) begin
      end else begin
         req_taken = 1'b0;
         offer = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_requests.size() > 0) begin
            nxt = pending_requests.pop_front();
            offer = 1'b1;
            send_gap = send_quiet ? 0 : int'($urandom_range(0, MAX_GAP));
            req_action       <= nxt.action;
            req_table_number <= nxt.table_number;
            req_table_entry  <= nxt.table_entry;
            req_entry_value  <= nxt.entry_value;
            req_data_block   <= nxt.data_block;
         end
         req_valid <= offer;
      end
   end

   always @(negedge clock) begin : receiver
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         if (rsp_valid) stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      request_type      got;
      block_result_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            stall_left = recv_quiet ? 0 : int'($urandom_range(0, MAX_GAP));
            if (blocks_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_result_block));
            end else begin
               due = blocks_due.pop_front();
               if (rsp_result_block !== due.result_block) begin
                  report_mismatch($sformatf("result_block %h, expected %h",
                                            rsp_result_block, due.result_block));
               end
               if (rsp_was_decrypt !== due.was_decrypt) begin
                  report_mismatch($sformatf("was_decrypt %b, expected %b",
                                            rsp_was_decrypt, due.was_decrypt));
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            requests_taken++;
            got.action       = req_action;
            got.table_number = req_table_number;
            got.table_entry  = req_table_entry;
            got.entry_value  = req_entry_value;
            got.data_block   = req_data_block;
            absorb_request(got);
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  perm [sbrc_pkg::TABLE_DEPTH];
      logic [7:0]  tmp;
      logic [7:0]  saved_hi;
      logic [7:0]  saved_lo;
      logic [63:0] plain;
      request_type rq;
      int          j;
      int          pick;
      int          zero_at;
      int          full_at;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_key(64'h0);

      // fill every table with a random permutation
      for (int t = 0; t < sbrc_pkg::NUM_TABLES; t++) begin
         for (int e = 0; e < sbrc_pkg::TABLE_DEPTH; e++) perm[e] = 8'(e);
         for (int e = sbrc_pkg::TABLE_DEPTH - 1; e > 0; e--) begin
            j = int'($urandom_range(0, e));
            tmp = perm[e];
            perm[e] = perm[j];
            perm[j] = tmp;
         end
         for (int e = 0; e < sbrc_pkg::TABLE_DEPTH; e++) queue_load(t, e, perm[e]);
      end
      drain();

      queue_block(sbrc_pkg::ACT_ENCRYPT, 64'h0);
      queue_block(sbrc_pkg::ACT_ENCRYPT, '1);
      queue_block(sbrc_pkg::ACT_DECRYPT, 64'h0);
      queue_block(sbrc_pkg::ACT_DECRYPT, '1);
      queue_request('{ACT_IGNORED, 3'd7, 8'hff, 8'hff, '1});
      queue_request('{ACT_IGNORED, 3'd0, 8'h00, 8'h00, 64'h0});
      queue_request(random_request(ACT_IGNORED));

      // break the permutation at the table extremes, use it, then repair
      saved_hi = plan_sbox[7][255];
      saved_lo = plan_sbox[0][0];
      zero_at  = find_value(7, 8'h00);
      full_at  = find_value(0, 8'hff);
      queue_load(7, 255, 8'h00);
      queue_load(0, 0, 8'hff);
      queue_block(sbrc_pkg::ACT_ENCRYPT, {$urandom, $urandom});
      queue_block(sbrc_pkg::ACT_DECRYPT, {$urandom, $urandom});
      queue_load(7, 255, saved_hi);
      queue_load(0, 0, saved_lo);
      queue_load(7, zero_at, 8'h00);
      queue_load(0, full_at, 8'hff);

      write_key('1);
      queue_block(sbrc_pkg::ACT_ENCRYPT, 64'h0);
      queue_block(sbrc_pkg::ACT_DECRYPT, '1);
      queue_swap(3, 0, 255);
      drain();
      plain = {$urandom, $urandom};
      queue_block(sbrc_pkg::ACT_ENCRYPT, plain);
      queue_block(sbrc_pkg::ACT_DECRYPT, encipher(plain));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: write_key(64'h0);
            2: write_key('1);
            default: write_key({$urandom, $urandom});
         endcase
         send_quiet = (phase == 1 || phase == 3);
         recv_quiet = (phase == 3);
         if (phase == 1) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2) drain();
            pick = int'($urandom_range(0, 99));
            if (pick < 40) begin
               queue_block(sbrc_pkg::ACT_ENCRYPT, {$urandom, $urandom});
            end else if (pick < 70) begin
               queue_block(sbrc_pkg::ACT_DECRYPT, {$urandom, $urandom});
            end else if (pick < 85) begin
               queue_swap(int'($urandom_range(0, 7)), int'($urandom_range(0, 255)),
                          int'($urandom_range(0, 255)));
            end else if (pick < 88) begin
               rq = random_request(sbrc_pkg::ACT_LOAD);
               queue_load(int'(rq.table_number), int'(rq.table_entry), rq.entry_value);
            end else if (pick < 93) begin
               queue_request(random_request(ACT_IGNORED));
            end else begin
               plain = {$urandom, $urandom};
               queue_block(sbrc_pkg::ACT_ENCRYPT, plain);
               queue_block(sbrc_pkg::ACT_DECRYPT, encipher(plain));
            end
         end
      end
      send_quiet = 1'b0;
      recv_quiet = 1'b0;

      drain();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
